### sv/stbs_pkg.sv
package stbs_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int INDEX_W         = 10;
	localparam int VALUE_W         = 32;
	localparam int COUNT_W         = 11;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic [INDEX_W-1:0]         entry_index;
		logic signed [VALUE_W-1:0]  entry_value;
		logic signed [VALUE_W-1:0]  search_key;
	} in_item_t;

	typedef struct packed {
		logic                found;
		logic [INDEX_W-1:0]  match_index;
	} out_item_t;

	// one queued request: a table write or a search, value and key share data
	typedef struct packed {
		logic                       is_search;
		logic [INDEX_W-1:0]         index;
		logic signed [VALUE_W-1:0]  data;
	} queue_entry_t;

endpackage

### sv/stbs_ram.sv
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/stbs_front.sv
module stbs_front #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                    item_valid,
	input  stbs_pkg::in_item_t      item,
	output logic                    item_stall,
	input  logic                    queue_full,
	output logic                    push,
	output stbs_pkg::queue_entry_t  push_entry
);

	logic is_search;
	logic in_range;

	assign is_search = (item.op == stbs_pkg::OP_SEARCH);
	// drop writes that land past the end of the table
	assign in_range  = (32'(item.entry_index) < 32'(TABLE_DEPTH));

	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full && (is_search || in_range);

	always_comb begin
		push_entry.is_search = is_search;
		push_entry.index     = item.entry_index;
		push_entry.data      = is_search ? item.search_key : item.entry_value;
	end

endmodule

### sv/stbs_queue.sv
module stbs_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  stbs_pkg::queue_entry_t  push_entry,
	output logic                    full,
	input  logic                    pop,
	output logic                    head_valid,
	output stbs_pkg::queue_entry_t  head
);

	localparam int PW = $clog2(stbs_pkg::QUEUE_DEPTH);
	localparam int NW = $clog2(stbs_pkg::QUEUE_DEPTH + 1);

	stbs_pkg::queue_entry_t entries_q [stbs_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (fill_q == NW'(stbs_pkg::QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(stbs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(stbs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### sv/stbs_back.sv
module stbs_back #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stbs_pkg::COUNT_W-1:0]  cfg_data,
	input  logic                          head_valid,
	input  stbs_pkg::queue_entry_t        head,
	output logic                          pop,
	output logic                          result_valid,
	input  logic                          result_stall,
	output stbs_pkg::out_item_t           result
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                             st_q;
	logic [CW-1:0]                      count_q;
	logic [CW-1:0]                      lo_q;
	logic [CW-1:0]                      hb_q;
	logic [AW-1:0]                      mid_q;
	logic signed [stbs_pkg::VALUE_W-1:0] key_q;
	logic                               hit_q;
	logic [AW-1:0]                      hit_idx_q;
	logic                               res_valid_q;
	stbs_pkg::out_item_t                res_q;

	logic [CW:0]                        mid_sum;
	logic [AW-1:0]                      mid;
	logic                               ram_we;
	logic                               ram_re;
	logic [stbs_pkg::VALUE_W-1:0]       ram_rdata;
	logic signed [stbs_pkg::VALUE_W-1:0] probe;
	logic                               probe_eq;
	logic                               probe_gt;
	logic [CW-1:0]                      new_lo;
	logic [CW-1:0]                      new_hb;
	logic                               load_res;

	assign cfg_ready = 1'b1;

	// live range is [lo, hb); midpoint rounds down
	assign mid_sum = {1'b0, lo_q} + {1'b0, hb_q} - (CW+1)'(1);
	assign mid     = mid_sum[AW:1];

	assign pop    = (st_q == ST_IDLE) && head_valid;
	assign ram_we = pop && !head.is_search;
	assign ram_re = (st_q == ST_READ);

	stbs_ram #(
		.WIDTH (stbs_pkg::VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(head.index)),
		.wdata (head.data),
		.re    (ram_re),
		.raddr (mid),
		.rdata (ram_rdata)
	);

	assign probe    = $signed(ram_rdata);
	assign probe_eq = (probe == key_q);
	assign probe_gt = (probe > key_q);

	always_comb begin
		if (probe_gt) begin
			new_lo = lo_q;
			new_hb = CW'(mid_q);
		end else begin
			new_lo = CW'(mid_q) + CW'(1);
			new_hb = hb_q;
		end
	end

	assign load_res = (st_q == ST_EMIT) && (!res_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				// saturate the count to the table depth
				count_q <= (32'(cfg_data) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cfg_data);
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (pop && head.is_search) begin
						st_q <= (count_q == '0) ? ST_EMIT : ST_READ;
					end
				end
				ST_READ: begin
					st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (probe_eq || !(new_lo < new_hb)) begin
						st_q <= ST_EMIT;
					end else begin
						st_q <= ST_READ;
					end
				end
				ST_EMIT: begin
					if (load_res) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_search) begin
			key_q     <= head.data;
			lo_q      <= '0;
			hb_q      <= count_q;
			hit_q     <= 1'b0;
			hit_idx_q <= '0;
		end
		if (st_q == ST_READ) begin
			mid_q <= mid;
		end
		if (st_q == ST_CMP) begin
			lo_q <= new_lo;
			hb_q <= new_hb;
			if (probe_eq) begin
				hit_q     <= 1'b1;
				hit_idx_q <= mid_q;
			end
		end
		if (load_res) begin
			res_q.found       <= hit_q;
			res_q.match_index <= stbs_pkg::INDEX_W'(hit_idx_q);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef NO_ASSERTIONS
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("table written and read in the same cycle");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_READ) |-> (lo_q < hb_q) && (hb_q <= count_q))
		else $error("probe issued on an empty or oversized range");

	a_cmp_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CMP) |-> ($past(st_q) == ST_READ) && (CW'(mid_q) < hb_q))
		else $error("compare without a matching read");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT && res_valid_q && result_stall) |=>
		(st_q == ST_EMIT) && $stable(res_q))
		else $error("pending result overwritten");
`endif

endmodule

### sv/sorted_table_binary_search.sv
// Sorted table with binary search. Software loads up to TABLE_DEPTH signed
// 32-bit values in ascending order with write requests (writes past the table
// end are dropped) and sets the number of live entries on the config port
// (counts above TABLE_DEPTH saturate). A search request returns found and the
// matching index, or found clear and index zero. Requests enter a two-entry
// queue and run in order in the back end: a write goes to the table as it is
// popped; a search makes P probes, where P is at most floor(log2(count)) + 1.
// Each probe takes a READ and a CMP state because the table RAM has a
// registered read that must land before the compare. A finished result sits
// in an output register, so while it is stalled the back end can still run the
// next request up to its emit, and the queue takes requests until it is full.
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stbs_pkg::COUNT_W-1:0]  cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  stbs_pkg::in_item_t            item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output stbs_pkg::out_item_t           result
);

	logic                    queue_full;
	logic                    push;
	stbs_pkg::queue_entry_t  push_entry;
	logic                    pop;
	logic                    head_valid;
	stbs_pkg::queue_entry_t  head;

	stbs_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	stbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	stbs_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
